@@ hdl/rtfp_pkg.sv @@
`timescale 1ns / 1ps
package rtfp_pkg;

    localparam int SLOT_BASE  = 4;
    localparam int SLOT_BYTES = 6;
    localparam int ANG_STEPS  = 90;
    localparam int TRIG_W     = 48;

    typedef logic [ANG_STEPS*TRIG_W-1:0] trig_tab_t;

    // floor(a*b / 2^60)
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[123:60];
    endfunction

    // sine or cosine of k degrees, Q46, built by Q60 rotation of one degree
    function automatic trig_tab_t build_trig(input logic want_cos);
        logic [63:0] t, t2, t3, t4, t5, t6, t7, t8, s1, c1, s, c, ns, nc, rs, rc;
        trig_tab_t   tab;
        tab = '0;
        t  = (64'h3243F6A8885A308D + 64'd90) / 64'd180;
        t2 = mul_q60(t, t);
        t3 = mul_q60(t2, t);
        t4 = mul_q60(t2, t2);
        t5 = mul_q60(t4, t);
        t6 = mul_q60(t4, t2);
        t7 = mul_q60(t6, t);
        t8 = mul_q60(t4, t4);
        s1 = t - t3 / 64'd6 + t5 / 64'd120 - t7 / 64'd5040;
        c1 = (64'd1 << 60) - t2 / 64'd2 + t4 / 64'd24 - t6 / 64'd720 + t8 / 64'd40320;
        s  = '0;
        c  = 64'd1 << 60;
        for (int k = 0; k < ANG_STEPS; k++)
        begin
            rs = (s + 64'd8192) >> 14;
            rc = (c + 64'd8192) >> 14;
            tab[k*TRIG_W +: TRIG_W] = want_cos ? rc[TRIG_W-1:0] : rs[TRIG_W-1:0];
            nc = mul_q60(c, c1) - mul_q60(s, s1);
            ns = mul_q60(s, c1) + mul_q60(c, s1);
            c  = nc;
            s  = ns;
        end
        return tab;
    endfunction

    localparam trig_tab_t SIN_TAB = build_trig(1'b0);
    localparam trig_tab_t COS_TAB = build_trig(1'b1);

    typedef struct packed {
        logic start;
        logic [1:0] slot;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic nonzero;
    } dp_sts_t;

endpackage

@@ hdl/rtfp_datapath.sv @@
`timescale 1ns / 1ps
module rtfp_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rtfp_pkg::dp_cmd_t    cmd,
    input  logic signed [15:0]   x_in,
    input  logic signed [15:0]   y_in,
    output rtfp_pkg::dp_sts_t    sts,
    output logic [15:0]          range_mag,
    output logic signed [8:0]    bearing_deg
);

    logic        busy_reg, busy_next;
    logic        sq_done_reg, sq_done_next;
    logic        an_done_reg, an_done_next;
    logic [31:0] n_reg, n_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] bit_reg, bit_next;
    logic [15:0] ax_reg, ay_reg;
    logic        xneg_reg, yneg_reg;
    logic [6:0]  k_reg, k_next;
    logic [6:0]  k_idx;
    logic [12:0] k_off;
    logic [47:0] sin_k, cos_k;
    logic [31:0] sq_x, sq_y;
    logic [63:0] lhs, rhs;
    logic [31:0] trial;
    logic [7:0]  b_abs;
    logic [8:0]  a_abs;
    logic        whole;

    assign sq_x  = 32'(x_in) * 32'(x_in);
    assign sq_y  = 32'(y_in) * 32'(y_in);
    assign trial = r_reg + bit_reg;
    assign k_idx = (k_reg < 7'(rtfp_pkg::ANG_STEPS)) ? k_reg : 7'(rtfp_pkg::ANG_STEPS - 1);
    assign k_off = 13'(k_idx) * 13'(rtfp_pkg::TRIG_W);
    assign sin_k = rtfp_pkg::SIN_TAB[k_off +: 48];
    assign cos_k = rtfp_pkg::COS_TAB[k_off +: 48];
    assign lhs   = 64'(ay_reg) * 64'(cos_k);
    assign rhs   = 64'(ax_reg) * 64'(sin_k);

    always_comb
    begin
        busy_next    = busy_reg;
        sq_done_next = sq_done_reg;
        an_done_next = an_done_reg;
        n_next       = n_reg;
        r_next       = r_reg;
        bit_next     = bit_reg;
        k_next       = k_reg;
        if (cmd.start)
        begin
            busy_next    = 1'b1;
            sq_done_next = 1'b0;
            an_done_next = (y_in == 16'sd0) || (x_in == 16'sd0) || (x_in == y_in)
                           || (x_in == -y_in);
            n_next       = sq_x + sq_y;
            r_next       = '0;
            bit_next     = 32'h4000_0000;
            k_next       = 7'd1;
        end
        else if (busy_reg)
        begin
            if (!sq_done_reg)
            begin
                if (n_reg >= trial)
                begin
                    n_next = n_reg - trial;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                    r_next = r_reg >> 1;
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                    sq_done_next = 1'b1;
            end
            if (!an_done_reg)
            begin
                if (k_reg < 7'(rtfp_pkg::ANG_STEPS) && lhs > rhs)
                    k_next = k_reg + 7'd1;
                else
                    an_done_next = 1'b1;
            end
            if (sq_done_reg && an_done_reg)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            sq_done_reg <= 1'b0;
            an_done_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            sq_done_reg <= sq_done_next;
            an_done_reg <= an_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
        k_reg   <= k_next;
        if (cmd.start)
        begin
            ax_reg   <= x_in[15] ? 16'(-x_in) : 16'(x_in);
            ay_reg   <= y_in[15] ? 16'(-y_in) : 16'(y_in);
            xneg_reg <= x_in[15];
            yneg_reg <= y_in[15];
        end
    end

    always_comb
    begin
        whole = 1'b0;
        b_abs = 8'(k_reg) - 8'd1;
        if (ay_reg == 16'd0)
        begin
            b_abs = 8'd0;
            whole = 1'b1;
        end
        else if (ax_reg == 16'd0)
        begin
            b_abs = 8'd90;
            whole = 1'b1;
        end
        else if (ax_reg == ay_reg)
        begin
            b_abs = 8'd45;
            whole = 1'b1;
        end
        if (xneg_reg)
            a_abs = 9'd180 - 9'(b_abs) - (whole ? 9'd0 : 9'd1);
        else
            a_abs = 9'(b_abs);
        bearing_deg = yneg_reg ? 9'(-$signed(a_abs)) : $signed(a_abs);
    end

    assign range_mag   = r_reg[15:0];
    assign sts.done    = sq_done_reg && an_done_reg;
    assign sts.nonzero = (x_in != 16'sd0) || (y_in != 16'sd0);

endmodule

@@ hdl/rtfp_ctrl.sv @@
`timescale 1ns / 1ps
module rtfp_ctrl #(
    parameter int TARGET_SLOTS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               frame_end,
    input  rtfp_pkg::dp_sts_t  sts,
    output rtfp_pkg::dp_cmd_t  cmd,
    output logic               emit,
    output logic               emit_empty,
    output logic               emit_last,
    output logic [1:0]         emit_kind,
    input  logic               out_free
);

    typedef enum logic [3:0] {
        S_RX   = 4'b0001,
        S_SCAN = 4'b0010,
        S_WAIT = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] slot_reg, slot_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] total_reg, total_next;
    logic       count_pass_reg, count_pass_next;
    logic       last_slot;

    assign last_slot = (slot_reg == 2'(TARGET_SLOTS - 1));
    assign in_stall  = (state_reg != S_RX);

    always_comb
    begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        cnt_next        = cnt_reg;
        total_next      = total_reg;
        count_pass_next = count_pass_reg;
        cmd.start       = 1'b0;
        cmd.slot        = slot_reg;
        emit            = 1'b0;
        emit_empty      = 1'b0;
        emit_last       = 1'b0;
        emit_kind       = (total_reg > 2'd1) ? 2'd2 : 2'd1;
        unique case (state_reg)
            S_RX:
            begin
                if (in_valid && frame_end)
                begin
                    state_next      = S_SCAN;
                    slot_next       = '0;
                    total_next      = '0;
                    cnt_next        = '0;
                    count_pass_next = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (count_pass_reg)
                begin
                    if (sts.nonzero)
                        total_next = total_reg + 2'd1;
                    if (last_slot)
                    begin
                        count_pass_next = 1'b0;
                        slot_next       = '0;
                        if (total_next == 2'd0)
                            state_next = S_EMIT;
                    end
                    else
                        slot_next = slot_reg + 2'd1;
                end
                else if (sts.nonzero)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_WAIT;
                end
                else
                    slot_next = slot_reg + 2'd1;
            end
            S_WAIT:
            begin
                if (sts.done && out_free)
                begin
                    emit      = 1'b1;
                    cnt_next  = cnt_reg + 2'd1;
                    emit_last = (cnt_next == total_reg);
                    if (emit_last)
                        state_next = S_RX;
                    else
                    begin
                        slot_next  = slot_reg + 2'd1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_empty = 1'b1;
                    emit_last  = 1'b1;
                    state_next = S_RX;
                end
            end
            default:
                state_next = S_RX;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_RX;
            slot_reg       <= '0;
            cnt_reg        <= '0;
            total_reg      <= '0;
            count_pass_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_reg       <= slot_next;
            cnt_reg        <= cnt_next;
            total_reg      <= total_next;
            count_pass_reg <= count_pass_next;
        end
    end

endmodule

@@ hdl/radar_target_frame_to_polar_unit.sv @@
`timescale 1ns / 1ps
// Radar frame decoder: bytes are counted into a frame, one per cycle while not stalled,
// with no header sync. On the last byte of a frame the input stalls; a pass counts the
// slots with a nonzero position, then each such target slot is converted to range and
// bearing by a bit-pair square root and a degree search that run side by side; a zero
// slot is skipped; up to 3 slots per frame.
// An empty frame gives one non-target result.
module radar_target_frame_to_polar_unit #(
    parameter int FRAME_BYTES  = 22,
    parameter int TARGET_SLOTS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               target_valid,
    output logic [1:0]         target_slot,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic signed [15:0] speed,
    output logic [15:0]        range_mag,
    output logic signed [8:0]  bearing_deg,
    output logic [1:0]         frame_kind,
    output logic               last_of_frame
);

    localparam int CW = $clog2(FRAME_BYTES);

    logic [7:0]    mem [FRAME_BYTES];
    logic [CW-1:0] cnt_reg;
    logic          frame_end;
    logic          accept;
    logic [CW-1:0] base;
    logic signed [15:0] sx, sy, sv;
    logic [15:0]   dp_range;
    logic signed [8:0] dp_bearing;
    logic          emit, emit_empty, emit_last, out_free;
    logic [1:0]    emit_kind;
    rtfp_pkg::dp_cmd_t cmd;
    rtfp_pkg::dp_sts_t sts;

    assign accept    = in_valid && !in_stall;
    assign frame_end = (cnt_reg == CW'(FRAME_BYTES - 1));
    assign base      = CW'(rtfp_pkg::SLOT_BASE + 0) + CW'(cmd.slot) * CW'(rtfp_pkg::SLOT_BYTES);
    assign sx = $signed({mem[base + CW'(1)], mem[base]});
    assign sy = $signed({mem[base + CW'(3)], mem[base + CW'(2)]});
    assign sv = $signed({mem[base + CW'(5)], mem[base + CW'(4)]});
    assign out_free = !out_valid || !out_stall;

    always_ff @(posedge clk)
    begin
        if (accept)
            mem[cnt_reg] <= rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (accept)
            cnt_reg <= frame_end ? '0 : cnt_reg + CW'(1);
    end

    rtfp_ctrl #(
        .TARGET_SLOTS (TARGET_SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .frame_end  (frame_end),
        .sts        (sts),
        .cmd        (cmd),
        .emit       (emit),
        .emit_empty (emit_empty),
        .emit_last  (emit_last),
        .emit_kind  (emit_kind),
        .out_free   (out_free)
    );

    rtfp_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .x_in        (sx),
        .y_in        (sy),
        .sts         (sts),
        .range_mag   (dp_range),
        .bearing_deg (dp_bearing)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (emit)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            target_valid  <= !emit_empty;
            target_slot   <= emit_empty ? 2'd0 : cmd.slot + 2'd1;
            pos_x         <= emit_empty ? 16'sd0 : sx;
            pos_y         <= emit_empty ? 16'sd0 : sy;
            speed         <= emit_empty ? 16'sd0 : sv;
            range_mag     <= emit_empty ? 16'd0 : dp_range;
            bearing_deg   <= emit_empty ? 9'sd0 : dp_bearing;
            frame_kind    <= emit_empty ? 2'd0 : emit_kind;
            last_of_frame <= emit_last;
        end
    end

endmodule

@@ hdl/rtfp_checker.sv @@
`timescale 1ns / 1ps
module rtfp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       target_valid,
    input logic [1:0] target_slot,
    input logic [1:0] frame_kind,
    input logic       last_of_frame
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !target_valid |-> target_slot == 2'd0 && frame_kind == 2'd0
        && last_of_frame)
        else $error("bad empty-frame result");

    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target_valid |-> target_slot != 2'd0 && frame_kind != 2'd0)
        else $error("target without slot or kind");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_frame |-> in_stall)
        else $error("input taken mid-frame output");

endmodule

bind radar_target_frame_to_polar_unit rtfp_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .target_valid  (target_valid),
    .target_slot   (target_slot),
    .frame_kind    (frame_kind),
    .last_of_frame (last_of_frame)
);
